// ----- design/bca_pkg.sv -----
// Shared types and constants for the block chain allocator.
// Depends on nothing; every other file of the block imports it.
package bca_pkg;

    localparam int BLK_W   = 11;
    localparam int LINK_W  = 12;
    localparam int CNT_W   = 12;
    localparam int BYTES_W = 20;
    localparam int OFF_W   = 12;
    localparam int BSIZE_W = 13;

    localparam logic [LINK_W-1:0]  END_OF_CHAIN = 12'hFFF;
    localparam logic [BSIZE_W-1:0] BSIZE_RESET  = 13'd510;
    localparam logic [BSIZE_W-1:0] BSIZE_MAX    = 13'd4096;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_LOCATE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_ZERO_SIZE  = 2'd2,
        ST_PAST_END   = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [BLK_W-1:0]   start_block;
        logic [BYTES_W-1:0] byte_count;
        logic [BYTES_W-1:0] byte_offset;
    } bca_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [BLK_W-1:0] block_index;
        logic [OFF_W-1:0] offset_in_block;
        logic [CNT_W-1:0] free_blocks;
    } bca_out_t;

    // One cycle's access to the free map and link table.
    typedef struct packed {
        logic [BLK_W-1:0]  raddr;
        logic              fm_we;
        logic [BLK_W-1:0]  fm_waddr;
        logic              fm_wdata;
        logic              ln_we;
        logic [BLK_W-1:0]  ln_waddr;
        logic [LINK_W-1:0] ln_wdata;
    } mem_req_t;

endpackage

// ----- design/bca_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bca_pkg for the field widths.
module bca_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [bca_pkg::BYTES_W-1:0]   dividend,
    input  logic [bca_pkg::BSIZE_W-1:0]   divisor,
    output logic                          done,
    output logic [bca_pkg::BYTES_W-1:0]   quot,
    output logic [bca_pkg::OFF_W-1:0]     rem
);
    import bca_pkg::*;

    localparam int CW = $clog2(BYTES_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [BYTES_W-1:0]  quot_reg, quot_next;
    logic [OFF_W-1:0]    rem_reg, rem_next;
    logic [BSIZE_W-1:0]  dvs_reg, dvs_next;
    logic [BSIZE_W-1:0]  trial;
    logic [BSIZE_W-1:0]  diff;
    logic                ge;

    // One shift-and-subtract step; the remainder stays below the divisor.
    assign trial = {rem_reg, quot_reg[BYTES_W-1]};
    assign ge    = (trial >= dvs_reg);
    assign diff  = trial - dvs_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(BYTES_W - 1);
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quot_next = {quot_reg[BYTES_W-2:0], ge};
            rem_next  = ge ? diff[OFF_W-1:0] : trial[OFF_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ----- design/bca_store.sv -----
// Free map and link table memories with registered reads, plus the
// free map clearing pass after reset. Depends on bca_pkg.
module bca_store #(
    parameter int USABLE = 2048
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bca_pkg::mem_req_t            req,
    output logic                         fm_rdata,
    output logic [bca_pkg::LINK_W-1:0]   ln_rdata,
    output logic                         clr_busy
);
    import bca_pkg::*;

    localparam int AW = (USABLE > 1) ? $clog2(USABLE) : 1;

    logic              fm_mem [USABLE];
    logic [LINK_W-1:0] ln_mem [USABLE];
    logic              fm_rdata_reg;
    logic [LINK_W-1:0] ln_rdata_reg;
    logic              clr_busy_reg;
    logic [AW-1:0]     clr_addr_reg;

    // Clearing pass: marks every block free, one entry per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(USABLE - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Free map: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            fm_mem[clr_addr_reg] <= 1'b1;
        end else if (req.fm_we) begin
            fm_mem[req.fm_waddr[AW-1:0]] <= req.fm_wdata;
        end
        fm_rdata_reg <= fm_mem[req.raddr[AW-1:0]];
    end

    // Link table: the port reads every cycle, but its data is only used for blocks that allocate has linked.
    always_ff @(posedge aclk) begin
        if (req.ln_we) begin
            ln_mem[req.ln_waddr[AW-1:0]] <= req.ln_wdata;
        end
        ln_rdata_reg <= ln_mem[req.raddr[AW-1:0]];
    end

    assign fm_rdata = fm_rdata_reg;
    assign ln_rdata = ln_rdata_reg;
    assign clr_busy = clr_busy_reg;

endmodule

// ----- design/block_chain_allocator.sv -----
// Top level of the block chain allocator: command sequencer, free count,
// block size register and output register. Depends on bca_pkg, bca_div, bca_store.
//
// After reset the block marks every block free and takes no word until that
// pass ends; configuration writes are taken throughout. One command is worked
// at a time, and the result sits in an output register so that the next word
// can be taken while it waits. Allocate runs the 20-step block-size divider,
// then scans blocks from block 0 up to the last free block it links. Locate
// runs the divider and then walks the chain block by block. Free walks the
// chain and returns each block. Every walk step is one registered read of the
// free map and link table, whose data gives the next address. Zero-size
// allocate and the undefined command go straight to the answer state.
module block_chain_allocator #(
    parameter int BLOCK_TOTAL = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bca_pkg::BSIZE_W-1:0]     cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  bca_pkg::bca_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output bca_pkg::bca_out_t               m_data
);
    import bca_pkg::*;

    localparam int USABLE = (BLOCK_TOTAL < 2048) ? BLOCK_TOTAL : 2048;
    localparam logic [LINK_W-1:0] USABLE_L = LINK_W'(USABLE);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b00_0000_0001,
        S_IDLE    = 10'b00_0000_0010,
        S_DIV     = 10'b00_0000_0100,
        S_ALLOC   = 10'b00_0000_1000,
        S_FREE_RD = 10'b00_0001_0000,
        S_FREE    = 10'b00_0010_0000,
        S_LOC_RD  = 10'b00_0100_0000,
        S_LOC     = 10'b00_1000_0000,
        S_DONE    = 10'b01_0000_0000,
        S_SPARE   = 10'b10_0000_0000
    } state_t;

    state_t              st_reg, st_next;
    bca_in_t             in_reg, in_next;
    logic [BSIZE_W-1:0]  bsize_reg;
    logic [BSIZE_W-1:0]  eff_bsize;
    logic [CNT_W-1:0]    fc_reg, fc_next;
    logic [LINK_W-1:0]   cur_reg, cur_next;
    logic [BYTES_W-1:0]  k_reg, k_next;
    logic [BYTES_W-1:0]  target_reg, target_next;
    logic [OFF_W-1:0]    inner_reg, inner_next;
    logic [CNT_W-1:0]    need_reg, need_next;
    logic [CNT_W-1:0]    got_reg, got_next;
    logic [BLK_W-1:0]    first_reg, first_next;
    logic [BLK_W-1:0]    prev_reg, prev_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                pv_reg, pv_next;
    logic [BLK_W-1:0]    paddr_reg, paddr_next;
    bca_out_t            res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    bca_out_t            m_data_reg, m_data_next;

    mem_req_t            req;
    logic                fm_rdata;
    logic [LINK_W-1:0]   ln_rdata;
    logic                clr_busy;
    logic                div_start;
    logic [BYTES_W-1:0]  div_dividend;
    logic                div_done;
    logic [BYTES_W-1:0]  div_quot;
    logic [OFF_W-1:0]    div_rem;
    logic [BYTES_W:0]    need_full;

    // Block size as used: zero acts as one, anything above 4096 as 4096.
    always_comb begin
        if (bsize_reg == '0) begin
            eff_bsize = BSIZE_W'(1);
        end else if (bsize_reg > BSIZE_MAX) begin
            eff_bsize = BSIZE_MAX;
        end else begin
            eff_bsize = bsize_reg;
        end
    end

    assign need_full = {1'b0, div_quot} + {{BYTES_W{1'b0}}, (div_rem != '0)};
    assign div_dividend = (cmd_t'(s_data.command) == CMD_ALLOC) ?
                          s_data.byte_count : s_data.byte_offset;

    bca_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (eff_bsize),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    bca_store #(.USABLE(USABLE)) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .fm_rdata (fm_rdata),
        .ln_rdata (ln_rdata),
        .clr_busy (clr_busy)
    );

    assign s_ready = (st_reg == S_IDLE);

    // Command sequencer.
    always_comb begin
        st_next     = st_reg;
        in_next     = in_reg;
        fc_next     = fc_reg;
        cur_next    = cur_reg;
        k_next      = k_reg;
        target_next = target_reg;
        inner_next  = inner_reg;
        need_next   = need_reg;
        got_next    = got_reg;
        first_next  = first_reg;
        prev_next   = prev_reg;
        scan_next   = scan_reg;
        pv_next     = 1'b0;
        paddr_next  = paddr_reg;
        res_next    = res_reg;
        div_start   = 1'b0;
        req         = '0;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (st_reg)
            S_CLEAR: begin
                if (!clr_busy) begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    in_next  = s_data;
                    cur_next = {1'b0, s_data.start_block};
                    k_next   = '0;
                    res_next = '0;
                    unique case (cmd_t'(s_data.command))
                        CMD_ALLOC: begin
                            if (s_data.byte_count == '0) begin
                                res_next.status = ST_ZERO_SIZE;
                                st_next = S_DONE;
                            end else begin
                                div_start = 1'b1;
                                st_next   = S_DIV;
                            end
                        end
                        CMD_FREE: begin
                            st_next = S_FREE_RD;
                        end
                        CMD_LOCATE: begin
                            div_start = 1'b1;
                            st_next   = S_DIV;
                        end
                        default: begin
                            st_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (cmd_t'(in_reg.command) == CMD_ALLOC) begin
                        if (need_full > {{(BYTES_W+1-CNT_W){1'b0}}, fc_reg}) begin
                            res_next.status = ST_NO_SPACE;
                            st_next = S_DONE;
                        end else begin
                            need_next = need_full[CNT_W-1:0];
                            got_next  = '0;
                            scan_next = '0;
                            st_next   = S_ALLOC;
                        end
                    end else begin
                        target_next = div_quot;
                        inner_next  = div_rem;
                        st_next     = S_LOC_RD;
                    end
                end
            end
            S_ALLOC: begin
                // Issue the next scan read while the previous one is judged.
                if (scan_reg < USABLE_L && got_reg < need_reg) begin
                    req.raddr  = scan_reg[BLK_W-1:0];
                    pv_next    = 1'b1;
                    paddr_next = scan_reg[BLK_W-1:0];
                    scan_next  = scan_reg + 1'b1;
                end
                if (got_reg == need_reg) begin
                    // Terminate the chain at its last block.
                    req.ln_we    = 1'b1;
                    req.ln_waddr = prev_reg;
                    req.ln_wdata = END_OF_CHAIN;
                    fc_next      = fc_reg - need_reg;
                    res_next.status      = ST_OK;
                    res_next.block_index = first_reg;
                    st_next = S_DONE;
                end else if (pv_reg && fm_rdata) begin
                    req.fm_we    = 1'b1;
                    req.fm_waddr = paddr_reg;
                    req.fm_wdata = 1'b0;
                    if (got_reg != '0) begin
                        req.ln_we    = 1'b1;
                        req.ln_waddr = prev_reg;
                        req.ln_wdata = {1'b0, paddr_reg};
                    end else begin
                        first_next = paddr_reg;
                    end
                    prev_next = paddr_reg;
                    got_next  = got_reg + 1'b1;
                end
            end
            S_FREE_RD: begin
                if (cur_reg < USABLE_L) begin
                    req.raddr = cur_reg[BLK_W-1:0];
                    st_next   = S_FREE;
                end else begin
                    st_next = S_DONE;
                end
            end
            S_FREE: begin
                // Links always point upward, so the next read never hits this write.
                if (!fm_rdata) begin
                    req.fm_we    = 1'b1;
                    req.fm_waddr = cur_reg[BLK_W-1:0];
                    req.fm_wdata = 1'b1;
                    fc_next      = fc_reg + 1'b1;
                    cur_next     = ln_rdata;
                    if (ln_rdata < USABLE_L) begin
                        req.raddr = ln_rdata[BLK_W-1:0];
                    end else begin
                        st_next = S_DONE;
                    end
                end else begin
                    st_next = S_DONE;
                end
            end
            S_LOC_RD: begin
                if (cur_reg < USABLE_L) begin
                    req.raddr = cur_reg[BLK_W-1:0];
                    st_next   = S_LOC;
                end else begin
                    res_next.status = ST_PAST_END;
                    st_next = S_DONE;
                end
            end
            S_LOC: begin
                if (fm_rdata) begin
                    res_next.status = ST_PAST_END;
                    st_next = S_DONE;
                end else if (k_reg == target_reg) begin
                    res_next.status          = ST_OK;
                    res_next.block_index     = cur_reg[BLK_W-1:0];
                    res_next.offset_in_block = inner_reg;
                    st_next = S_DONE;
                end else if (ln_rdata < USABLE_L) begin
                    req.raddr = ln_rdata[BLK_W-1:0];
                    cur_next  = ln_rdata;
                    k_next    = k_reg + 1'b1;
                end else begin
                    res_next.status = ST_PAST_END;
                    st_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    m_data_next.free_blocks = fc_reg;
                    st_next = S_IDLE;
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= S_CLEAR;
            fc_reg      <= CNT_W'(USABLE);
            bsize_reg   <= BSIZE_RESET;
            m_valid_reg <= 1'b0;
            pv_reg      <= 1'b0;
        end else begin
            st_reg      <= st_next;
            fc_reg      <= fc_next;
            m_valid_reg <= m_valid_next;
            pv_reg      <= pv_next;
            if (cfg_wr_en) begin
                bsize_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        cur_reg    <= cur_next;
        k_reg      <= k_next;
        target_reg <= target_next;
        inner_reg  <= inner_next;
        need_reg   <= need_next;
        got_reg    <= got_next;
        first_reg  <= first_next;
        prev_reg   <= prev_next;
        scan_reg   <= scan_next;
        paddr_reg  <= paddr_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The free count never exceeds the number of usable blocks.
    a_fc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fc_reg <= CNT_W'(USABLE))
        else $error("free count above usable blocks");

    // An allocation in progress never asks for more than is free.
    a_need_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_ALLOC) |-> (need_reg <= fc_reg && got_reg <= need_reg))
        else $error("allocation exceeds free count");

    // A word is only taken once the clearing pass has finished.
    a_no_take_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_ready)
        else $error("input taken during clearing pass");

    // The divider reports completion only while a command waits on it.
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (st_reg == S_DIV))
        else $error("divider done outside divide state");

endmodule

// ----- bench/tb_block_chain_allocator.sv -----
// Self-checking testbench for block_chain_allocator: allocate, free, locate and
// undefined commands against a behavioral model of the link table and free map.
// Depends on bca_pkg and the block_chain_allocator RTL.
module tb_block_chain_allocator;
    import bca_pkg::*;

    localparam int NBLK = 2048;

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [BSIZE_W-1:0] cfg_wr_data;
    logic s_valid;
    logic s_ready;
    bca_in_t s_data;
    logic m_valid;
    logic m_ready;
    bca_out_t m_data;

    block_chain_allocator #(.BLOCK_TOTAL(NBLK)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Shadow copy of the allocator state.
    logic [LINK_W-1:0] sh_link [NBLK];
    logic sh_free [NBLK];
    int unsigned sh_free_cnt;
    logic [BSIZE_W-1:0] sh_bsize;

    bca_out_t expected_words[$];
    int unsigned error_count;
    bit stall_on;
    // Heads of chains the stimulus has allocated and not yet freed.
    int unsigned live_heads[$];

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic bit block_in_use(input int unsigned b);
        return b < NBLK && !sh_free[b];
    endfunction

    // Computes the answer to one command and updates the shadow state.
    function automatic bca_out_t allocator_answer(input bca_in_t w);
        bca_out_t r;
        int unsigned bs, need, got, prev, b, nxt, k, target;
        bs = (sh_bsize == 0) ? 1 : (sh_bsize > 4096) ? 4096 : 32'(sh_bsize);
        r = '0;
        r.status = ST_OK;
        case (cmd_t'(w.command))
            CMD_ALLOC: begin
                if (w.byte_count == 0) begin
                    r.status = ST_ZERO_SIZE;
                end else begin
                    need = (32'(w.byte_count) + bs - 1) / bs;
                    if (need > sh_free_cnt) begin
                        r.status = ST_NO_SPACE;
                    end else begin
                        got = 0;
                        prev = 0;
                        for (b = 0; b < NBLK && got < need; b++) begin
                            if (sh_free[b]) begin
                                sh_free[b] = 1'b0;
                                sh_link[b] = END_OF_CHAIN;
                                if (got == 0) r.block_index = BLK_W'(b);
                                else sh_link[prev] = LINK_W'(b);
                                prev = b;
                                got++;
                            end
                        end
                        sh_free_cnt -= got;
                    end
                end
            end
            CMD_FREE: begin
                b = 32'(w.start_block);
                k = 0;
                while (block_in_use(b) && k < NBLK) begin
                    nxt = 32'(sh_link[b]);
                    sh_link[b] = END_OF_CHAIN;
                    sh_free[b] = 1'b1;
                    sh_free_cnt++;
                    b = nxt;
                    k++;
                end
            end
            CMD_LOCATE: begin
                target = 32'(w.byte_offset) / bs;
                b = 32'(w.start_block);
                k = 0;
                if (!block_in_use(b)) begin
                    b = 32'(END_OF_CHAIN);
                end
                while (b != 32'(END_OF_CHAIN) && k < target) begin
                    if (k >= NBLK) begin
                        b = 32'(END_OF_CHAIN);
                    end else begin
                        b = 32'(sh_link[b]);
                        if (!block_in_use(b)) b = 32'(END_OF_CHAIN);
                        k++;
                    end
                end
                if (b == 32'(END_OF_CHAIN)) begin
                    r.status = ST_PAST_END;
                end else begin
                    r.block_index = BLK_W'(b);
                    r.offset_in_block = OFF_W'(32'(w.byte_offset) % bs);
                end
            end
            default: ;
        endcase
        r.free_blocks = CNT_W'(sh_free_cnt);
        return r;
    endfunction

    // Sends one word, after a random gap while stall_on is set, and queues its expected answer.
    task automatic send_word(input cmd_t c, input int unsigned start,
                             input int unsigned cnt, input int unsigned off);
        bca_in_t w;
        int unsigned gap;
        w.command = c;
        w.start_block = BLK_W'(start);
        w.byte_count = BYTES_W'(cnt);
        w.byte_offset = BYTES_W'(off);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                           : $urandom_range(0, 2);
        if (!stall_on) gap = 0;
        // The previous word dropped valid at this falling edge; move on first.
        repeat (gap + 1) @(negedge aclk);
        s_data <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_words.push_back(allocator_answer(w));
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Waits for every answer, then lets the block settle.
    task automatic drain;
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_block_bytes(input int unsigned v);
        drain();
        cfg_wr_data <= BSIZE_W'(v);
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sh_bsize = BSIZE_W'(v);
    endtask

    // Receiver stalls.
    always @(negedge aclk) begin
        if (!stall_on) m_ready <= 1'b1;
        else if ($urandom_range(0, 15) == 0) m_ready <= 1'b0;
        else if ($urandom_range(0, 2) == 0) m_ready <= 1'b1;
    end

    // Compares every accepted answer with the oldest expectation.
    always @(posedge aclk) begin
        bca_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = expected_words.pop_front();
                if (m_data.status != want.status)
                    report_mismatch("status", m_data.status, want.status);
                if (m_data.block_index != want.block_index)
                    report_mismatch("block_index", m_data.block_index, want.block_index);
                if (m_data.offset_in_block != want.offset_in_block)
                    report_mismatch("offset_in_block", m_data.offset_in_block,
                                    want.offset_in_block);
                if (m_data.free_blocks != want.free_blocks)
                    report_mismatch("free_blocks", m_data.free_blocks, want.free_blocks);
            end
        end
    end

    task automatic test_directed;
        send_word(CMD_ALLOC, 2047, 0, 1048575);
        send_word(CMD_ALLOC, 0, 1, 0);
        send_word(CMD_ALLOC, 0, 1020, 0);
        send_word(CMD_ALLOC, 0, 1021, 0);
        send_word(CMD_LOCATE, 1, 510, 0);
        send_word(CMD_LOCATE, 1, 1020, 0);
        send_word(CMD_LOCATE, 3, 0, 1529);
        send_word(CMD_LOCATE, 3, 0, 1530);
        send_word(CMD_LOCATE, 2047, 0, 0);
        send_word(CMD_NONE, 2047, 1048575, 1048575);
        send_word(CMD_FREE, 1, 0, 0);
        send_word(CMD_FREE, 1, 0, 0);
        send_word(CMD_LOCATE, 0, 0, 1048575);
        send_word(CMD_ALLOC, 0, 1048575, 0);
        send_word(CMD_ALLOC, 0, 500000, 0);
        send_word(CMD_FREE, 0, 0, 0);
        send_word(CMD_FREE, 3, 0, 0);
        send_word(CMD_FREE, 5, 0, 0);
    endtask

    task automatic test_block_size(input int unsigned v);
        write_block_bytes(v);
        send_word(CMD_ALLOC, 0, 9000, 0);
        send_word(CMD_LOCATE, 0, 0, 8999);
        send_word(CMD_LOCATE, 0, 0, v);
        send_word(CMD_FREE, 0, 0, 0);
        send_word(CMD_ALLOC, 0, 1048575, 0);
        send_word(CMD_FREE, 0, 0, 0);
    endtask

    // Mostly well-formed allocate/locate/free sequences on live chains.
    task automatic test_random(input int unsigned n);
        int unsigned i, pick, sel, cnt;
        for (i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1048575)
                                                     : $urandom_range(1, 6 * 510);
                send_word(CMD_ALLOC, $urandom_range(0, 2047), cnt,
                          $urandom_range(0, 1048575));
                if (expected_words[$].status == ST_OK)
                    live_heads.push_back(expected_words[$].block_index);
            end else if (pick < 70 && live_heads.size() != 0) begin
                sel = $urandom_range(0, live_heads.size() - 1);
                send_word(CMD_LOCATE, live_heads[sel], $urandom_range(0, 1048575),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1048575)
                                                      : $urandom_range(0, 4000));
            end else if (pick < 92 && live_heads.size() != 0) begin
                sel = $urandom_range(0, live_heads.size() - 1);
                send_word(CMD_FREE, live_heads[sel], $urandom_range(0, 1048575),
                          $urandom_range(0, 1048575));
                live_heads.delete(sel);
            end else begin
                send_word(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 2047),
                          $urandom_range(0, 1048575), $urandom_range(0, 1048575));
                if (expected_words[$].status == ST_OK && s_data.command == CMD_FREE)
                    live_heads.delete();
            end
            if (sh_free_cnt < 64) begin
                while (live_heads.size() != 0)
                    send_word(CMD_FREE, live_heads.pop_front(), 0, 0);
            end
        end
        // Leave no chain behind so a later size change starts clean.
        while (live_heads.size() != 0)
            send_word(CMD_FREE, live_heads.pop_front(), 0, 0);
    endtask

    initial begin
        int unsigned b;
        error_count = 0;
        stall_on = 1'b1;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b1;
        for (b = 0; b < NBLK; b++) begin
            sh_link[b] = END_OF_CHAIN;
            sh_free[b] = 1'b1;
        end
        sh_free_cnt = NBLK;
        sh_bsize = BSIZE_RESET;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random(600);
        test_block_size(1);
        test_block_size(0);
        test_block_size(8191);
        test_block_size(4096);
        test_block_size(4097);
        write_block_bytes(64);
        stall_on = 1'b0;
        test_random(300);
        stall_on = 1'b1;
        test_random(300);
        write_block_bytes(1000);
        test_random(500);
        drain();

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #100000000;
        $display("status: fail");
        $finish;
    end

endmodule
